### rtl/core/assert_macros.svh
// assertion macros shared by the mixer rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mixer assertion failed");
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("mixer assertion failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_ALWAYS(label, prop)
`endif
`endif

### rtl/core/stmix_pkg.sv
// shared types, constants and fixed-point helpers for the stereo mixer
// quarter-sine table is built at elaboration; no dependencies
`default_nettype none
package stmix_pkg;

	localparam int NUM_INPUTS = 4;
	localparam int NUM_LANES = 4;
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH) + 1;
	localparam int POS_W = 23 + IDX_W;
	localparam int PROD_W = 41;
	localparam int ACC_W = PROD_W + 2;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// taylor series denominators (2k)(2k+1) for k = 1..7
	localparam longint unsigned TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	localparam logic [NUM_LANES-1:0] IN_MASK = NUM_LANES'((1 << NUM_INPUTS) - 1);
	localparam logic signed [24:0] PHASE_ONE = 25'sd8388608;
	localparam logic signed [24:0] PHASE_HALF = 25'sd4194304;

	localparam logic [63:0] LEVELS_RST = 64'h4000400040004000;
	localparam logic [13:0] FLAGS_RST = 14'd8207;
	localparam logic [15:0] MASTER_RST = 16'd16384;
	localparam logic [15:0] COEF_RST = 16'd65208;
	localparam logic [15:0] XCOEF_RST = 16'd64881;
	localparam logic [23:0] LEVEL_Y_RST = 24'h400000;
	localparam logic [15:0] FADED_RST = 16'd16384;

	typedef logic [15:0] sine_rom_t [0:SINE_TABLE_DEPTH];

	typedef struct packed {
		logic smooth;
		logic trig_cos;
		logic trig_sin;
		logic prod_l;
		logic prod_r;
	} lane_ctl_t;

	typedef struct packed {
		logic smooth;
		logic trig;
		logic fade;
		logic sel;
	} xf_ctl_t;

	typedef struct packed {
		logic master;
		logic sum;
		logic scale;
		logic finish;
		logic zero;
	} mrg_ctl_t;

	function automatic logic [15:0] sine_of_q30(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k];
			if ((k & 1) != 0) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		sum = (sum + 16384) >>> 15;
		return (sum > 32768) ? 16'd32768 : 16'(sum);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t r;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
			r[i] = sine_of_q30(longint'(unsigned'(i)) * HALF_PI_Q30 / SINE_TABLE_DEPTH);
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// quarter sine with linear interpolation, phase 0..2^23 maps 0..pi/2
	function automatic logic [15:0] sin_interp(input logic signed [24:0] p);
		logic [23:0] pc;
		logic [POS_W-1:0] pos;
		logic [IDX_W-1:0] idx;
		logic [22:0] frac;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [38:0] dlt;
		logic [15:0] res;
		if (p < 0) pc = '0;
		else if (p > PHASE_ONE) pc = 24'd8388608;
		else pc = p[23:0];
		pos = POS_W'(pc) * POS_W'(SINE_TABLE_DEPTH);
		idx = pos[POS_W-1:23];
		frac = pos[22:0];
		if (idx >= IDX_W'(SINE_TABLE_DEPTH)) begin
			res = SINE_ROM[SINE_TABLE_DEPTH];
		end else begin
			lo = SINE_ROM[idx];
			hi = SINE_ROM[IDX_W'(idx + 1'b1)];
			if (hi < lo) hi = lo;
			dlt = 39'(hi - lo) * 39'(frac) + 39'd4194304;
			res = lo + 16'(dlt >> 23);
		end
		return res;
	endfunction

	// one-pole step y += (1-a)(target-y), rounded to nearest, ties upward
	function automatic logic signed [24:0] smooth_step(input logic signed [24:0] y,
			input logic signed [16:0] target, input logic [15:0] coef);
		logic signed [25:0] diff;
		logic signed [17:0] m;
		logic signed [43:0] prod;
		logic signed [27:0] delta;
		diff = ($signed({target, 8'b0}) >>> 0) - 26'(y);
		m = 18'sd65536 - $signed({2'b00, coef});
		prod = 44'(diff) * 44'(m) + 44'sd32768;
		delta = 28'(prod >>> 16);
		return 25'(y + 25'(delta));
	endfunction

	function automatic logic [15:0] clamp_level(input logic [15:0] v);
		return (v > 16'd32768) ? 16'd32768 : v;
	endfunction

	function automatic logic signed [15:0] clamp_pan(input logic signed [15:0] v);
		logic signed [15:0] r;
		if (v > 16'sd16384) r = 16'sd16384;
		else if (v < -16'sd16384) r = -16'sd16384;
		else r = v;
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/core/stmix_lane.sv
// one mixer channel: level and pan smoothers, equal-power gains, sample products
// depends on stmix_pkg
`default_nettype none
module stmix_lane
	import stmix_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire lane_ctl_t                ctl,
	input  wire logic                     part,
	input  wire logic [15:0]              level_tgt,
	input  wire logic signed [15:0]       pan_tgt,
	input  wire logic [15:0]              coef,
	input  wire logic signed [15:0]       sample_l,
	input  wire logic signed [15:0]       sample_r,
	output logic signed [PROD_W-1:0]      prod_l,
	output logic signed [PROD_W-1:0]      prod_r
);

	logic [23:0] level_q;
	logic signed [23:0] pan_q;
	logic [15:0] trig_q;
	logic [23:0] gain_l_q;
	logic [23:0] gain_r_q;
	logic signed [PROD_W-1:0] prod_l_q;
	logic signed [PROD_W-1:0] prod_r_q;
	logic [23:0] gain_now;
	logic [39:0] gain_full;

	always_comb begin
		gain_full = 40'(level_q) * 40'(trig_q) + 40'd16384;
		gain_now = 24'(gain_full >> 15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_Y_RST;
			pan_q <= '0;
		end else if (ctl.smooth && part) begin
			level_q <= 24'(smooth_step($signed({1'b0, level_q}), $signed({1'b0, level_tgt}),
				coef));
			pan_q <= 24'(smooth_step(25'(pan_q), 17'(pan_tgt), coef));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.trig_cos)
			trig_q <= sin_interp(PHASE_HALF - 25'(pan_q));
		if (ctl.trig_sin) begin
			gain_l_q <= gain_now;
			trig_q <= sin_interp(25'(pan_q) + PHASE_HALF);
		end
		if (ctl.prod_l) begin
			gain_r_q <= gain_now;
			prod_l_q <= part ? PROD_W'(sample_l) * PROD_W'($signed({1'b0, gain_l_q})) : '0;
		end
		if (ctl.prod_r)
			prod_r_q <= part ? PROD_W'(sample_r) * PROD_W'($signed({1'b0, gain_r_q})) : '0;
	end

	assign prod_l = prod_l_q;
	assign prod_r = prod_r_q;

endmodule
`default_nettype wire

### rtl/core/stmix_xfade.sv
// crossfade smoother and faded level targets of inputs 0 and 1
// depends on stmix_pkg
`default_nettype none
module stmix_xfade
	import stmix_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire xf_ctl_t     ctl,
	input  wire logic [15:0] xpos_tgt,
	input  wire logic [15:0] xcoef,
	input  wire logic [15:0] level0,
	input  wire logic [15:0] level1,
	output logic [15:0]      faded [2]
);

	logic [23:0] xf_q;
	logic [15:0] trig_q;
	logic [15:0] faded_q [2];
	logic [15:0] level_sel;
	logic [31:0] fade_full;

	always_comb begin
		level_sel = ctl.sel ? level1 : level0;
		fade_full = 32'(level_sel) * 32'(trig_q) + 32'd16384;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xf_q <= '0;
			faded_q[0] <= FADED_RST;
			faded_q[1] <= FADED_RST;
		end else begin
			if (ctl.smooth)
				xf_q <= 24'(smooth_step($signed({1'b0, xf_q}), $signed({1'b0, xpos_tgt}),
					xcoef));
			if (ctl.fade)
				faded_q[ctl.sel] <= 16'(fade_full >> 15);
		end
	end

	// input 0 takes the cosine, input 1 the sine
	always_ff @(posedge clk) begin
		if (ctl.trig)
			trig_q <= ctl.sel ? sin_interp($signed({1'b0, xf_q}))
				: sin_interp(PHASE_ONE - $signed({1'b0, xf_q}));
	end

	assign faded[0] = faded_q[0];
	assign faded[1] = faded_q[1];

endmodule
`default_nettype wire

### rtl/core/stmix_merge.sv
// merge of lane products, master smoother, master scaling and saturation
// depends on stmix_pkg
`default_nettype none
module stmix_merge
	import stmix_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mrg_ctl_t                 ctl,
	input  wire logic [15:0]              master_tgt,
	input  wire logic [15:0]              coef,
	input  wire logic signed [PROD_W-1:0] prod_l [NUM_LANES],
	input  wire logic signed [PROD_W-1:0] prod_r [NUM_LANES],
	output logic signed [23:0]            mix_left,
	output logic signed [23:0]            mix_right
);

	logic [23:0] master_q;
	logic signed [ACC_W-1:0] acc_l_q;
	logic signed [ACC_W-1:0] acc_r_q;
	logic signed [45:0] sc_l_q;
	logic signed [45:0] sc_r_q;
	logic signed [23:0] mix_l_q;
	logic signed [23:0] mix_r_q;
	logic signed [ACC_W-1:0] sum_l;
	logic signed [ACC_W-1:0] sum_r;
	logic signed [20:0] rnd_l;
	logic signed [20:0] rnd_r;
	logic signed [24:0] out_l;
	logic signed [24:0] out_r;

	function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
		logic signed [23:0] r;
		if (v > 25'sd8388607) r = 24'sh7fffff;
		else if (v < -25'sd8388608) r = 24'sh800000;
		else r = v[23:0];
		return r;
	endfunction

	always_comb begin
		sum_l = '0;
		sum_r = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			sum_l = sum_l + ACC_W'(prod_l[i]);
			sum_r = sum_r + ACC_W'(prod_r[i]);
		end
		rnd_l = 21'((acc_l_q + ACC_W'(2097152)) >>> 22);
		rnd_r = 21'((acc_r_q + ACC_W'(2097152)) >>> 22);
		out_l = 25'((sc_l_q + 46'sd2097152) >>> 22);
		out_r = 25'((sc_r_q + 46'sd2097152) >>> 22);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= {MASTER_RST, 8'b0};
		end else if (ctl.master) begin
			master_q <= 24'(smooth_step($signed({1'b0, master_q}), $signed({1'b0, master_tgt}),
				coef));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sum) begin
			acc_l_q <= sum_l;
			acc_r_q <= sum_r;
		end
		if (ctl.scale) begin
			sc_l_q <= 46'(rnd_l) * 46'($signed({1'b0, master_q}));
			sc_r_q <= 46'(rnd_r) * 46'($signed({1'b0, master_q}));
		end
		if (ctl.finish) begin
			mix_l_q <= ctl.zero ? '0 : sat24(out_l);
			mix_r_q <= ctl.zero ? '0 : sat24(out_r);
		end
	end

	assign mix_left = mix_l_q;
	assign mix_right = mix_r_q;

endmodule
`default_nettype wire

### rtl/core/stereo_mixer_equal_power_pan_top.sv
// stereo mixer top: configuration registers, sequencer, lanes, crossfade and merge
// depends on stmix_pkg, stmix_lane, stmix_xfade, stmix_merge, assert_macros.svh
//
//  channel | handshake              | payload
//  in      | in_valid / in_stall    | in0..in3 left/right, block_start
//  out     | out_valid / out_stall  | mix_left, mix_right
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// after acceptance an item runs through 14 sequencer steps (crossfade smoother
// and fades for inputs 0 and 1, lane smoothing, cos/sin interpolation, gains
// and products, merge sum, master scale, rounding); inactive frames skip to rounding
// each lane's sine lookups, gain multiply and products are enabled in separate steps
// reset clears the configuration to its defaults and all smoothers to them
// a stalled result holds the sequencer at its last step; input stalls while busy
`default_nettype none
`include "assert_macros.svh"
module stereo_mixer_equal_power_pan_top
	import stmix_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] in0_left,
	input  wire logic signed [15:0] in0_right,
	input  wire logic signed [15:0] in1_left,
	input  wire logic signed [15:0] in1_right,
	input  wire logic signed [15:0] in2_left,
	input  wire logic signed [15:0] in2_right,
	input  wire logic signed [15:0] in3_left,
	input  wire logic signed [15:0] in3_right,
	input  wire logic               block_start,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [23:0]      mix_left,
	output logic signed [23:0]      mix_right,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [63:0]        cfg_data
);

	localparam logic [2:0] REG_LEVELS = 3'd0;
	localparam logic [2:0] REG_PANS   = 3'd1;
	localparam logic [2:0] REG_FLAGS  = 3'd2;
	localparam logic [2:0] REG_XPOS   = 3'd3;
	localparam logic [2:0] REG_MASTER = 3'd4;
	localparam logic [2:0] REG_COEF   = 3'd5;
	localparam logic [2:0] REG_XCOEF  = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE, S_XF0_SM, S_XF0_TRIG, S_XF0_FADE, S_XF1_SM, S_XF1_TRIG, S_XF1_FADE,
		S_LANE_SM, S_LANE_COS, S_LANE_SIN, S_LANE_PL, S_LANE_PR, S_SUM, S_SCALE, S_FINISH
	} state_t;

	state_t state_q;
	logic zero_q;
	logic out_valid_q;

	logic [63:0] levels_q;
	logic [63:0] pans_q;
	logic [13:0] flags_q;
	logic [15:0] xpos_q;
	logic [15:0] master_lvl_q;
	logic [15:0] coef_q;
	logic [15:0] xcoef_q;

	logic signed [15:0] smp_l_q [NUM_LANES];
	logic signed [15:0] smp_r_q [NUM_LANES];
	logic block_start_q;

	logic [NUM_LANES-1:0] solo;
	logic [NUM_LANES-1:0] part;
	logic any_solo;
	logic xf_on;
	logic active;
	logic go0;
	logic go1;
	logic accept;
	logic out_free;

	lane_ctl_t lane_ctl;
	xf_ctl_t xf_ctl;
	mrg_ctl_t mrg_ctl;

	logic [15:0] level_c [NUM_LANES];
	logic [15:0] faded [2];
	logic signed [PROD_W-1:0] prod_l [NUM_LANES];
	logic signed [PROD_W-1:0] prod_r [NUM_LANES];

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		solo = flags_q[11:8] & IN_MASK;
		any_solo = |solo;
		part = flags_q[3:0] & ~flags_q[7:4] & (any_solo ? solo : '1) & IN_MASK;
		xf_on = flags_q[12];
		active = flags_q[13];
		go0 = xf_on && block_start_q && part[0];
		go1 = xf_on && block_start_q && part[1];
		for (int c = 0; c < NUM_LANES; c++)
			level_c[c] = clamp_level(levels_q[16*c +: 16]);
	end

	always_comb begin
		lane_ctl = '0;
		xf_ctl = '0;
		mrg_ctl = '0;
		mrg_ctl.zero = zero_q;
		unique case (state_q)
			S_XF0_SM:   xf_ctl.smooth = go0;
			S_XF0_TRIG: xf_ctl.trig = go0;
			S_XF0_FADE: xf_ctl.fade = go0;
			S_XF1_SM: begin
				xf_ctl.smooth = go1;
				xf_ctl.sel = 1'b1;
			end
			S_XF1_TRIG: begin
				xf_ctl.trig = go1;
				xf_ctl.sel = 1'b1;
			end
			S_XF1_FADE: begin
				xf_ctl.fade = go1;
				xf_ctl.sel = 1'b1;
			end
			S_LANE_SM: begin
				lane_ctl.smooth = 1'b1;
				mrg_ctl.master = 1'b1;
			end
			S_LANE_COS: lane_ctl.trig_cos = 1'b1;
			S_LANE_SIN: lane_ctl.trig_sin = 1'b1;
			S_LANE_PL:  lane_ctl.prod_l = 1'b1;
			S_LANE_PR:  lane_ctl.prod_r = 1'b1;
			S_SUM:      mrg_ctl.sum = 1'b1;
			S_SCALE:    mrg_ctl.scale = 1'b1;
			S_FINISH:   mrg_ctl.finish = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			zero_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						zero_q <= !active;
						state_q <= active ? S_XF0_SM : S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= state_t'(state_q + 4'd1);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= LEVELS_RST;
			pans_q <= '0;
			flags_q <= FLAGS_RST;
			xpos_q <= '0;
			master_lvl_q <= MASTER_RST;
			coef_q <= COEF_RST;
			xcoef_q <= XCOEF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LEVELS: levels_q <= cfg_data;
				REG_PANS:   pans_q <= cfg_data;
				REG_FLAGS:  flags_q <= cfg_data[13:0];
				REG_XPOS:   xpos_q <= cfg_data[15:0];
				REG_MASTER: master_lvl_q <= cfg_data[15:0];
				REG_COEF:   coef_q <= cfg_data[15:0];
				REG_XCOEF:  xcoef_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_l_q[0] <= in0_left;
			smp_r_q[0] <= in0_right;
			smp_l_q[1] <= in1_left;
			smp_r_q[1] <= in1_right;
			smp_l_q[2] <= in2_left;
			smp_r_q[2] <= in2_right;
			smp_l_q[3] <= in3_left;
			smp_r_q[3] <= in3_right;
			block_start_q <= block_start;
		end
	end

	stmix_xfade u_xfade (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (xf_ctl),
		.xpos_tgt (clamp_level(xpos_q)),
		.xcoef    (xcoef_q),
		.level0   (level_c[0]),
		.level1   (level_c[1]),
		.faded    (faded)
	);

	for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
		if (c < NUM_INPUTS) begin : g_on
			logic [15:0] tgt;
			if (c < 2) begin : g_fade
				assign tgt = xf_on ? faded[c] : level_c[c];
			end else begin : g_plain
				assign tgt = level_c[c];
			end
			stmix_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (lane_ctl),
				.part      (part[c]),
				.level_tgt (tgt),
				.pan_tgt   (clamp_pan(pans_q[16*c +: 16])),
				.coef      (coef_q),
				.sample_l  (smp_l_q[c]),
				.sample_r  (smp_r_q[c]),
				.prod_l    (prod_l[c]),
				.prod_r    (prod_r[c])
			);
		end else begin : g_off
			assign prod_l[c] = '0;
			assign prod_r[c] = '0;
		end
	end

	stmix_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mrg_ctl),
		.master_tgt (clamp_level(master_lvl_q)),
		.coef       (coef_q),
		.prod_l     (prod_l),
		.prod_r     (prod_r),
		.mix_left   (mix_left),
		.mix_right  (mix_right)
	);

	`ASSERT_CLK(a_out_from_finish, $rose(out_valid_q) |-> $past(state_q == S_FINISH))
	`ASSERT_CLK(a_accept_leaves_idle, accept |=> (state_q != S_IDLE))
	`ASSERT_CLK(a_finish_delivers, (state_q == S_FINISH && out_free) |=> out_valid_q)

endmodule
`default_nettype wire

### tb/stereo_mixer_equal_power_pan_top_tb.sv
// testbench for the stereo mixer: directed frames, then random frames under
// several register settings, checked against typed-in pairs or a cycle-free mixing predictor
// depends on stereo_mixer_equal_power_pan_top only
`default_nettype none
module stereo_mixer_equal_power_pan_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		REG_LEVELS, REG_PANS, REG_FLAGS, REG_XPOS, REG_MASTER, REG_COEF, REG_XCOEF
	} reg_index_t;

	localparam int FLAG_XFADE = 12;
	localparam int FLAG_ACTIVE = 13;
	localparam longint PHASE_FULL = 64'sd8388608;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam int ROM_DEPTH = 256;
	localparam int IDLE_LIMIT = 4000;
	localparam int PHASES = 11;

	typedef struct {
		logic signed [15:0] smp [8];
		bit block_first;
		bit has_mix;
		logic signed [23:0] exp_left;
		logic signed [23:0] exp_right;
	} frame_t;

	typedef struct {
		logic signed [23:0] left;
		logic signed [23:0] right;
	} mix_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [15:0] smp_drv [8];
	logic block_start = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [23:0] mix_left, mix_right;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [63:0] cfg_data = 0;

	// register copies and smoother state of the predictor
	logic [63:0] levels_reg, pans_reg;
	logic [13:0] flags_reg;
	logic [15:0] xpos_reg, master_reg, coef_reg, xcoef_reg;
	longint level_y [4], pan_y [4], faded_tgt [2];
	longint xfade_y, master_y;
	longint unsigned quarter_sine [ROM_DEPTH+1];

	mix_t pending_mix [$];
	int failures = 0;
	bit quiet = 0;
	int idle_cycles = 0;
	int stall_burst = 0;

	always #1 clk = ~clk;

	stereo_mixer_equal_power_pan_top dut (
		.clk, .arst_n, .in_valid, .in_stall,
		.in0_left(smp_drv[0]), .in0_right(smp_drv[1]),
		.in1_left(smp_drv[2]), .in1_right(smp_drv[3]),
		.in2_left(smp_drv[4]), .in2_right(smp_drv[5]),
		.in3_left(smp_drv[6]), .in3_right(smp_drv[7]),
		.block_start, .out_valid, .out_stall, .mix_left, .mix_right,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	function automatic longint rnd_shift(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// taylor series of sin on a Q30 angle, rounded to Q1.15
	function automatic longint unsigned taylor_sine(longint unsigned x);
		longint unsigned sq, term;
		longint acc;
		sq = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * sq) >> 30) / longint'((2 * k) * (2 * k + 1));
			acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
		end
		if (acc < 0) acc = 0;
		acc = (acc + 16384) >>> 15;
		return (acc > 32768) ? 32768 : longint'(acc);
	endfunction

	function automatic longint sine_at(longint p);
		longint unsigned pos, idx, frac, lo, hi;
		if (p < 0) p = 0;
		if (p > PHASE_FULL) p = PHASE_FULL;
		pos = longint'(p) * ROM_DEPTH;
		idx = pos >> 23;
		frac = pos & (PHASE_FULL - 1);
		if (idx >= ROM_DEPTH) return quarter_sine[ROM_DEPTH];
		lo = quarter_sine[idx];
		hi = quarter_sine[idx + 1];
		if (hi < lo) hi = lo;
		return longint'(lo + (((hi - lo) * frac + (PHASE_FULL / 2)) >> 23));
	endfunction

	function automatic longint cosine_at(longint p);
		return sine_at(PHASE_FULL - p);
	endfunction

	function automatic longint follow(longint y, longint tgt, logic [15:0] a);
		return y + rnd_shift((tgt * 256 - y) * (65536 - longint'(a)), 16);
	endfunction

	function automatic longint level_tgt(int c);
		longint v;
		v = longint'(levels_reg[16*c +: 16]);
		return (v > 32768) ? 32768 : v;
	endfunction

	function automatic longint pan_tgt(int c);
		longint v;
		v = longint'($signed(pans_reg[16*c +: 16]));
		return (v > 16384) ? 16384 : ((v < -16384) ? -16384 : v);
	endfunction

	function automatic longint clip_u15(logic [15:0] v);
		return (v > 16'd32768) ? 32768 : longint'(v);
	endfunction

	function automatic logic signed [23:0] saturate24(longint v);
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[23:0];
	endfunction

	// advances the smoothers by one active frame and returns the mixed pair, zero if inactive
	function automatic mix_t mix_frame(frame_t f);
		mix_t r;
		bit soloed, xf_on;
		longint acc_l, acc_r, tgt, trig, ph, gl, gr;
		r.left = '0;
		r.right = '0;
		if (!flags_reg[FLAG_ACTIVE]) return r;
		soloed = |flags_reg[11:8];
		xf_on = flags_reg[FLAG_XFADE];
		acc_l = 0;
		acc_r = 0;
		for (int c = 0; c < 4; c++) begin
			if (!flags_reg[c] || flags_reg[4+c]) continue;
			if (soloed && !flags_reg[8+c]) continue;
			tgt = level_tgt(c);
			if (xf_on && c < 2) begin
				if (f.block_first) begin
					xfade_y = follow(xfade_y, clip_u15(xpos_reg), xcoef_reg);
					trig = (c == 0) ? cosine_at(xfade_y) : sine_at(xfade_y);
					faded_tgt[c] = rnd_shift(tgt * trig, 15);
				end
				tgt = faded_tgt[c];
			end
			level_y[c] = follow(level_y[c], tgt, coef_reg);
			pan_y[c] = follow(pan_y[c], pan_tgt(c), coef_reg);
			ph = pan_y[c] + PHASE_FULL / 2;
			gl = rnd_shift(level_y[c] * cosine_at(ph), 15);
			gr = rnd_shift(level_y[c] * sine_at(ph), 15);
			acc_l += longint'(f.smp[2*c]) * gl;
			acc_r += longint'(f.smp[2*c+1]) * gr;
		end
		master_y = follow(master_y, clip_u15(master_reg), coef_reg);
		r.left = saturate24(rnd_shift(rnd_shift(acc_l, 22) * master_y, 22));
		r.right = saturate24(rnd_shift(rnd_shift(acc_r, 22) * master_y, 22));
		return r;
	endfunction

	task automatic write_reg(reg_index_t idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LEVELS: levels_reg = val;
			REG_PANS:   pans_reg = val;
			REG_FLAGS:  flags_reg = val[13:0];
			REG_XPOS:   xpos_reg = val[15:0];
			REG_MASTER: master_reg = val[15:0];
			REG_COEF:   coef_reg = val[15:0];
			REG_XCOEF:  xcoef_reg = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic drain();
		in_valid = 0;
		while (pending_mix.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_frame(frame_t f);
		mix_t m;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		foreach (smp_drv[i]) smp_drv[i] = f.smp[i];
		block_start = f.block_first;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		m = mix_frame(f);
		// typed-in rows are checked against their own expected pair
		if (f.has_mix) begin
			m.left = f.exp_left;
			m.right = f.exp_right;
		end
		pending_mix.push_back(m);
		@(negedge clk);
	endtask

	function automatic frame_t random_frame(int bs_odds);
		frame_t f;
		for (int i = 0; i < 8; i++) f.smp[i] = 16'($urandom());
		case ($urandom_range(0, 7))
			0: for (int i = 0; i < 8; i++)
				f.smp[i] = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
			1: for (int i = 0; i < 8; i++)
				f.smp[i] = 16'($signed(16'($urandom_range(0, 15))) - 8);
			default: ;
		endcase
		f.block_first = ($urandom_range(0, bs_odds) == 0);
		f.has_mix = 0;
		return f;
	endfunction

	// receiver backpressure in random bursts
	always @(negedge clk) begin
		if (!quiet && stall_burst > 0) begin
			stall_burst--;
			out_stall <= 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_burst = $urandom_range(0, 14);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		mix_t want;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_mix.size() == 0) begin
				$error("unexpected item: mix_left %0d mix_right %0d", mix_left, mix_right);
				failures++;
			end else begin
				want = pending_mix.pop_front();
				if (mix_left !== want.left) begin
					$error("mix_left expected %0d got %0d", want.left, mix_left);
					failures++;
				end
				if (mix_right !== want.right) begin
					$error("mix_right expected %0d got %0d", want.right, mix_right);
					failures++;
				end
			end
		end
	end

	initial begin
		frame_t rows [12];
		frame_t f;
		logic [13:0] fl;
		foreach (smp_drv[i]) smp_drv[i] = '0;
		for (int i = 0; i <= ROM_DEPTH; i++)
			quarter_sine[i] = taylor_sine(longint'(i) * QUARTER_TURN_Q30 / ROM_DEPTH);
		levels_reg = 64'h4000400040004000;
		pans_reg = '0;
		flags_reg = 14'd8207;
		xpos_reg = 0;
		master_reg = 16'd16384;
		coef_reg = 16'd65208;
		xcoef_reg = 16'd64881;
		for (int c = 0; c < 4; c++) begin
			level_y[c] = 16384 * 256;
			pan_y[c] = 0;
		end
		faded_tgt[0] = 16384;
		faded_tgt[1] = 16384;
		xfade_y = 0;
		master_y = 16384 * 256;

		// silence mixes to zero; everything else goes through the predictor
		foreach (rows[r]) begin
			for (int i = 0; i < 8; i++) rows[r].smp[i] = '0;
			rows[r].block_first = 0;
			rows[r].has_mix = 0;
			rows[r].exp_left = '0;
			rows[r].exp_right = '0;
		end
		rows[0].has_mix = 1;
		rows[1].block_first = 1;
		rows[1].has_mix = 1;
		for (int i = 0; i < 8; i++) begin
			rows[2].smp[i] = 16'sh7fff;
			rows[3].smp[i] = 16'sh8000;
			rows[4].smp[i] = (i % 2) ? 16'sh8000 : 16'sh7fff;
			rows[5].smp[i] = 16'sh0001;
			rows[6].smp[i] = -16'sh0001;
			rows[7].smp[i] = (i % 2) ? 16'sh5555 : 16'shaaaa;
			rows[8].smp[i] = (i % 2) ? 16'shaaaa : 16'sh5555;
			rows[11].smp[i] = 16'sh4000;
		end
		rows[8].block_first = 1;
		rows[9].smp[0] = 16'sh7fff;
		rows[10].smp[7] = 16'sh8000;
		rows[10].block_first = 1;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (rows[r]) send_frame(rows[r]);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin
					// clamped extremes, crossfade on with instant smoothers
					write_reg(REG_LEVELS, 64'hffff_8000_0000_7fff);
					write_reg(REG_PANS, 64'h8000_7fff_c000_4000);
					write_reg(REG_FLAGS, 14'h300f);
					write_reg(REG_XPOS, 16'hffff);
					write_reg(REG_MASTER, 16'hffff);
					write_reg(REG_COEF, 16'h0000);
					write_reg(REG_XCOEF, 16'h0000);
				end
				1: begin
					// solo with a muted soloed channel, slowest smoothers
					write_reg(REG_FLAGS, 14'h3a2f);
					write_reg(REG_COEF, 16'hffff);
					write_reg(REG_XCOEF, 16'hffff);
					write_reg(REG_MASTER, 16'h0000);
					write_reg(REG_XPOS, 16'h0000);
				end
				2: write_reg(REG_FLAGS, 14'h1fff);
				3: begin
					write_reg(REG_FLAGS, 14'h3000);
					write_reg(REG_MASTER, 16'h8000);
					write_reg(REG_XPOS, 16'h8000);
				end
				default: begin
					fl = 14'($urandom());
					if ($urandom_range(0, 3) != 0) fl[11:4] = fl[11:4] & 8'($urandom());
					fl[FLAG_ACTIVE] = ($urandom_range(0, 9) != 0);
					write_reg(REG_LEVELS, {$urandom(), $urandom()} &
						{4{16'h8000 | 16'($urandom())}});
					write_reg(REG_PANS, {$urandom(), $urandom()});
					write_reg(REG_FLAGS, fl);
					write_reg(REG_XPOS, $urandom_range(0, 1) ? $urandom_range(0, 32768)
						: $urandom());
					write_reg(REG_MASTER, $urandom_range(0, 40000));
					write_reg(REG_COEF, $urandom_range(0, 1) ? $urandom_range(60000, 65535)
						: $urandom());
					write_reg(REG_XCOEF, $urandom_range(0, 1) ? $urandom_range(60000, 65535)
						: $urandom());
				end
			endcase
			if (ph == PHASES - 1) quiet = 1;
			repeat (ph < 4 ? 60 : 200) send_frame(random_frame(ph % 2 ? 3 : 15));
		end

		in_valid = 0;
		while (pending_mix.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

### stereo_mixer_equal_power_pan_top.f
+incdir+rtl/core
rtl/core/stmix_pkg.sv
rtl/core/stmix_lane.sv
rtl/core/stmix_xfade.sv
rtl/core/stmix_merge.sv
rtl/core/stereo_mixer_equal_power_pan_top.sv
tb/stereo_mixer_equal_power_pan_top_tb.sv
